@@ rtl/core/accel_step_counter_assert.svh @@
// assertion macros used by asc_track, the step counter tracking module
`ifndef ACCEL_STEP_COUNTER_ASSERT_SVH
`define ACCEL_STEP_COUNTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ASC_ASSERT_SAME(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASC_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/core/asc_pkg.sv @@
// shared widths, register codes, reset values and types of the step counter
package asc_pkg;

    localparam int unsigned AXIS_W     = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DAY_W      = 27;
    localparam int unsigned COUNT_W    = 24;
    localparam int unsigned THR_W      = 15;
    localparam int unsigned GAP_W      = 16;
    localparam int unsigned PROD_W     = 2 * AXIS_W;
    localparam int unsigned SQ_W       = PROD_W - 1;
    localparam int unsigned MAG_W      = SQ_W + 1;
    localparam int unsigned THR_SQ_W   = 2 * THR_W;
    localparam int unsigned CFG_DATA_W = COUNT_W;
    localparam int unsigned CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REARM_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP_MS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GOAL       = 2'd3;

    // reset values, thresholds kept squared
    localparam logic [THR_SQ_W-1:0] STEP_THR_SQ_RST  = THR_SQ_W'(4833 * 4833);
    localparam logic [THR_SQ_W-1:0] REARM_THR_SQ_RST = THR_SQ_W'(4301 * 4301);
    localparam logic [GAP_W-1:0]    MIN_GAP_RST      = GAP_W'(280);
    localparam logic [COUNT_W-1:0]  STEP_GOAL_RST    = COUNT_W'(10000);

    localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_write_t;

    typedef struct packed {
        logic ge_step;
        logic lt_rearm;
    } mag_flags_t;

endpackage

@@ rtl/core/asc_ifs.sv @@
// sample and result channel interfaces of the step counter
interface sample_if
    import asc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] accel_x;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_z;
    logic [TIME_W-1:0]        now_ms;
    logic [DAY_W-1:0]         day_key;

    modport source (output valid, accel_x, accel_y, accel_z, now_ms, day_key, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, now_ms, day_key, output ready);
endinterface

interface result_if
    import asc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               step_counted;
    logic               goal_reached;
    logic [COUNT_W-1:0] steps_today;
    logic [DAY_W-1:0]   current_day;

    modport source (output valid, step_counted, goal_reached, steps_today, current_day,
                    input ready);
    modport sink (input valid, step_counted, goal_reached, steps_today, current_day,
                  output ready);
endinterface

@@ rtl/core/asc_mag.sv @@
// input register, squared magnitude and threshold compare stages
module asc_mag
    import asc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  cfg_write_t        cfg,
    sample_if.sink            sample,
    output logic              mag_valid,
    output mag_flags_t        mag_flags,
    output logic [TIME_W-1:0] mag_now,
    output logic [DAY_W-1:0]  mag_day
);

    logic                     in_valid_reg;
    logic signed [AXIS_W-1:0] ax_reg;
    logic signed [AXIS_W-1:0] ay_reg;
    logic signed [AXIS_W-1:0] az_reg;
    logic [TIME_W-1:0]        in_now_reg;
    logic [DAY_W-1:0]         in_day_reg;

    logic                     sq_valid_reg;
    logic [SQ_W-1:0]          sq_x_reg;
    logic [SQ_W-1:0]          sq_y_reg;
    logic [SQ_W-1:0]          sq_z_reg;
    logic [TIME_W-1:0]        sq_now_reg;
    logic [DAY_W-1:0]         sq_day_reg;

    logic                     cmp_valid_reg;
    mag_flags_t               flags_reg;
    mag_flags_t               flags_next;
    logic [TIME_W-1:0]        cmp_now_reg;
    logic [DAY_W-1:0]         cmp_day_reg;

    logic [THR_SQ_W-1:0]      step_sq_reg;
    logic [THR_SQ_W-1:0]      rearm_sq_reg;
    logic [THR_SQ_W-1:0]      thr_sq_next;

    logic signed [PROD_W-1:0] prod_x;
    logic signed [PROD_W-1:0] prod_y;
    logic signed [PROD_W-1:0] prod_z;
    logic [MAG_W-1:0]         mag_sq;

    assign sample.ready = adv;

    // thresholds are squared once, on the write
    assign thr_sq_next = cfg.data[THR_W-1:0] * cfg.data[THR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_sq_reg  <= STEP_THR_SQ_RST;
            rearm_sq_reg <= REARM_THR_SQ_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_STEP_THRESHOLD:  step_sq_reg  <= thr_sq_next;
                CFG_REARM_THRESHOLD: rearm_sq_reg <= thr_sq_next;
                default: ;
            endcase
        end
    end

    // per-axis squares, always nonnegative
    assign prod_x = ax_reg * ax_reg;
    assign prod_y = ay_reg * ay_reg;
    assign prod_z = az_reg * az_reg;

    // sum of squares against both squared thresholds
    assign mag_sq = MAG_W'(sq_x_reg) + MAG_W'(sq_y_reg) + MAG_W'(sq_z_reg);
    always_comb
    begin
        flags_next.ge_step  = (mag_sq >= MAG_W'(step_sq_reg));
        flags_next.lt_rearm = (mag_sq < MAG_W'(rearm_sq_reg));
    end

    // stage valid bits move together with the output side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            cmp_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg  <= sample.valid;
            sq_valid_reg  <= in_valid_reg;
            cmp_valid_reg <= sq_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg      <= sample.accel_x;
            ay_reg      <= sample.accel_y;
            az_reg      <= sample.accel_z;
            in_now_reg  <= sample.now_ms;
            in_day_reg  <= sample.day_key;
            sq_x_reg    <= prod_x[SQ_W-1:0];
            sq_y_reg    <= prod_y[SQ_W-1:0];
            sq_z_reg    <= prod_z[SQ_W-1:0];
            sq_now_reg  <= in_now_reg;
            sq_day_reg  <= in_day_reg;
            flags_reg   <= flags_next;
            cmp_now_reg <= sq_now_reg;
            cmp_day_reg <= sq_day_reg;
        end
    end

    assign mag_valid = cmp_valid_reg;
    assign mag_flags = flags_reg;
    assign mag_now   = cmp_now_reg;
    assign mag_day   = cmp_day_reg;

endmodule

@@ rtl/core/asc_track.sv @@
// day tracking, step detector state, goal pulse and result register
module asc_track
    import asc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_write_t        cfg,
    input  logic              mag_valid,
    input  mag_flags_t        mag_flags,
    input  logic [TIME_W-1:0] mag_now,
    input  logic [DAY_W-1:0]  mag_day,
    output logic              adv,
    result_if.source          result
);

`include "accel_step_counter_assert.svh"

    logic [GAP_W-1:0]   min_gap_reg;
    logic [COUNT_W-1:0] goal_reg;

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [DAY_W-1:0]   day_reg;
    logic [DAY_W-1:0]   day_next;
    logic               armed_reg;
    logic               armed_next;
    logic               goal_done_reg;
    logic               goal_done_next;
    logic [TIME_W-1:0]  last_reg;
    logic [TIME_W-1:0]  last_next;

    logic               res_valid_reg;
    logic               res_step_reg;
    logic               res_goal_reg;
    logic [COUNT_W-1:0] res_steps_reg;
    logic [DAY_W-1:0]   res_day_reg;

    logic               upd;
    logic               new_day;
    logic [COUNT_W-1:0] count_base;
    logic               armed_base;
    logic               goal_done_base;
    logic [TIME_W-1:0]  last_base;
    logic [TIME_W-1:0]  gap;
    logic               gap_ok;
    logic               trigger;
    logic               fire;
    logic [COUNT_W-1:0] count_inc;
    logic               goal_hit;

    // pipeline moves when the result register is free or being emptied
    assign adv = !res_valid_reg || result.ready;
    assign upd = adv && mag_valid;

    // configuration registers used here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_gap_reg <= MIN_GAP_RST;
            goal_reg    <= STEP_GOAL_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                CFG_MIN_GAP_MS: min_gap_reg <= cfg.data[GAP_W-1:0];
                CFG_STEP_GOAL:  goal_reg    <= cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // new day clears the daily state before the step test
    assign new_day        = (mag_day != '0) && (mag_day != day_reg);
    assign count_base     = new_day ? '0 : count_reg;
    assign armed_base     = new_day ? 1'b1 : armed_reg;
    assign goal_done_base = new_day ? 1'b0 : goal_done_reg;
    assign last_base      = new_day ? '0 : last_reg;

    // gap test, wrapping time, skipped with no earlier step
    assign gap     = mag_now - last_base;
    assign gap_ok  = (last_base == '0) || (gap >= TIME_W'(min_gap_reg));
    assign trigger = mag_flags.ge_step && armed_base;
    assign fire    = trigger && gap_ok;

    // saturating count and goal crossing
    assign count_inc = (count_base != COUNT_MAX) ? count_base + COUNT_W'(1) : count_base;
    assign goal_hit  = fire && !goal_done_base && (count_base < goal_reg)
                       && (count_inc >= goal_reg);

    always_comb
    begin
        day_next       = new_day ? mag_day : day_reg;
        count_next     = fire ? count_inc : count_base;
        goal_done_next = goal_done_base || goal_hit;
        last_next      = fire ? mag_now : last_base;
        if (fire)
            armed_next = 1'b0;
        else if (!trigger && mag_flags.lt_rearm)
            armed_next = 1'b1;
        else
            armed_next = armed_base;
    end

    // detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            day_reg       <= '0;
            armed_reg     <= 1'b1;
            goal_done_reg <= 1'b0;
            last_reg      <= '0;
        end
        else if (upd)
        begin
            count_reg     <= count_next;
            day_reg       <= day_next;
            armed_reg     <= armed_next;
            goal_done_reg <= goal_done_next;
            last_reg      <= last_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (adv)
            res_valid_reg <= mag_valid;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            res_step_reg  <= fire;
            res_goal_reg  <= goal_hit;
            res_steps_reg <= count_next;
            res_day_reg   <= day_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.step_counted = res_step_reg;
    assign result.goal_reached = res_goal_reg;
    assign result.steps_today  = res_steps_reg;
    assign result.current_day  = res_day_reg;

    // goal flag only rises together with a delivered goal pulse
    `ASC_ASSERT_SAME(a_goal_flag_pulse, $rose(goal_done_reg), res_valid_reg && res_goal_reg,
                     "goal flag set without goal pulse")
    // a counted step leaves the detector disarmed
    `ASC_ASSERT_SAME(a_step_disarms, res_valid_reg && res_step_reg, !armed_reg,
                     "detector armed after counted step")
    // reported count is the stored count
    `ASC_ASSERT_SAME(a_count_matches, res_valid_reg, res_steps_reg == count_reg,
                     "result count differs from stored count")
    // saturated count holds within a day
    `ASC_ASSERT_NEXT(a_count_saturates, upd && !new_day && (count_reg == COUNT_MAX),
                     count_reg == COUNT_MAX, "saturated count moved")

endmodule

@@ rtl/core/accel_step_counter.sv @@
// Step counter: one accelerometer sample accepted per clock while no result
// waits, one result per sample, passed through input register, squares,
// magnitude compare, state update and result register. Throughput is one
// sample per cycle while no result waits; the whole pipeline holds
// while a result waits, and sample.ready follows result.ready through the
// result register. Thresholds are squared when written and the magnitude is
// compared squared in 1/4096 g units. Configuration writes take effect on the
// next cycle; the user makes them while no sample is in flight, and the block does not enforce this.
module accel_step_counter
    import asc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sample_if.sink                sample,
    result_if.source              result
);

    cfg_write_t        cfg;
    logic              adv;
    logic              mag_valid;
    mag_flags_t        mag_flags;
    logic [TIME_W-1:0] mag_now;
    logic [DAY_W-1:0]  mag_day;

    // bundle the write port
    always_comb
    begin
        cfg.we    = cfg_we;
        cfg.index = cfg_index;
        cfg.data  = cfg_data;
    end

    // magnitude pipeline
    asc_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .sample    (sample),
        .mag_valid (mag_valid),
        .mag_flags (mag_flags),
        .mag_now   (mag_now),
        .mag_day   (mag_day)
    );

    // step state and result register
    asc_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .mag_valid (mag_valid),
        .mag_flags (mag_flags),
        .mag_now   (mag_now),
        .mag_day   (mag_day),
        .adv       (adv),
        .result    (result)
    );

endmodule

@@ tb/tb_accel_step_counter.sv @@
// self-checking testbench for the accelerometer step counter
module tb_accel_step_counter;
    import asc_pkg::*;

    typedef struct packed {
        logic [AXIS_W-1:0] accel_x;
        logic [AXIS_W-1:0] accel_y;
        logic [AXIS_W-1:0] accel_z;
        logic [TIME_W-1:0] now_ms;
        logic [DAY_W-1:0]  day_key;
    } sample_t;

    typedef struct packed {
        logic               step_counted;
        logic               goal_reached;
        logic [COUNT_W-1:0] steps_today;
        logic [DAY_W-1:0]   current_day;
    } step_result_t;

    typedef enum int {
        SHAPE_PEAK,
        SHAPE_TROUGH,
        SHAPE_BETWEEN,
        SHAPE_NOISE,
        SHAPE_EXACT_STEP,
        SHAPE_EXACT_REARM
    } shape_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sample_if sample_ch ();
    result_if result_ch ();

    accel_step_counter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // register copies
    logic [THR_W-1:0]   step_thr;
    logic [THR_W-1:0]   rearm_thr;
    logic [GAP_W-1:0]   gap_ms;
    logic [COUNT_W-1:0] goal_steps;

    // daily detector state
    logic [COUNT_W-1:0] day_steps;
    logic [DAY_W-1:0]   held_day;
    logic               armed;
    logic               goal_hit;
    logic [TIME_W-1:0]  last_step_ms;

    sample_t      sample_queue[$];
    step_result_t step_results_due[$];
    sample_t      in_flight;

    int unsigned samples_queued;
    int unsigned samples_taken;
    int unsigned results_seen;
    int unsigned steps_seen;
    int unsigned goals_seen;
    int unsigned settings_used;
    int unsigned errors;
    int unsigned send_hold;
    int unsigned send_calm;
    int unsigned take_hold;
    int unsigned take_calm;

    logic [TIME_W-1:0] walk_ms;
    logic [DAY_W-1:0]  walk_day;
    bit                walk_high;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // next state and result of the detector for one sample
    function automatic step_result_t count_step(input sample_t s);
        longint            ax;
        longint            ay;
        longint            az;
        longint            mag_sq;
        longint            step_sq;
        longint            rearm_sq;
        longint            thr;
        logic [TIME_W-1:0] since_last;
        logic [COUNT_W-1:0] prior;
        step_result_t      r;
        ax = $signed(s.accel_x);
        ay = $signed(s.accel_y);
        az = $signed(s.accel_z);
        mag_sq = ax * ax + ay * ay + az * az;
        thr = step_thr;
        step_sq = thr * thr;
        thr = rearm_thr;
        rearm_sq = thr * thr;
        r = '0;
        // new calendar day clears the count
        if (s.day_key != '0 && s.day_key != held_day)
        begin
            held_day     = s.day_key;
            day_steps    = '0;
            armed        = 1'b1;
            goal_hit     = 1'b0;
            last_step_ms = '0;
        end
        if (mag_sq >= step_sq && armed)
        begin
            since_last = s.now_ms - last_step_ms;
            if (last_step_ms == '0 || since_last >= TIME_W'(gap_ms))
            begin
                prior = day_steps;
                if (day_steps != COUNT_MAX)
                    day_steps = day_steps + 1'b1;
                if (!goal_hit && prior < goal_steps && day_steps >= goal_steps)
                begin
                    r.goal_reached = 1'b1;
                    goal_hit       = 1'b1;
                end
                r.step_counted = 1'b1;
                last_step_ms   = s.now_ms;
                armed          = 1'b0;
            end
        end
        else if (mag_sq < rearm_sq)
        begin
            armed = 1'b1;
        end
        r.steps_today = day_steps;
        r.current_day = held_day;
        return r;
    endfunction

    // idle length: mostly short, a few long, with runs of no idling
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned roll;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t sample_at(input int ax, input int ay, input int az,
                                          input logic [TIME_W-1:0] now,
                                          input int unsigned day);
        sample_t s;
        s.accel_x = AXIS_W'(ax);
        s.accel_y = AXIS_W'(ay);
        s.accel_z = AXIS_W'(az);
        s.now_ms  = now;
        s.day_key = DAY_W'(day);
        return s;
    endfunction

    // sample whose magnitude sits where the shape asks, relative to the thresholds
    function automatic sample_t make_sample(input shape_t shape, input logic [TIME_W-1:0] now,
                                            input logic [DAY_W-1:0] day);
        int st;
        int rt;
        int lead;
        int lane;
        int axis [3];
        st = step_thr;
        rt = rearm_thr;
        lead = 0;
        for (int k = 0; k < 3; k++)
            axis[k] = 0;
        case (shape)
            SHAPE_PEAK:
            begin
                lead = st + $urandom_range(0, 3000);
                if (lead > 32767)
                    lead = 32767;
                for (int k = 0; k < 3; k++)
                    axis[k] = $urandom_range(0, 1500);
            end
            SHAPE_TROUGH:
            begin
                lead = $urandom_range(0, rt * 3 / 5);
                for (int k = 0; k < 3; k++)
                    axis[k] = $urandom_range(0, rt * 2 / 5);
            end
            SHAPE_BETWEEN:
                lead = (rt < st) ? $urandom_range(rt, st - 1) : rt;
            SHAPE_EXACT_STEP:
                lead = st;
            SHAPE_EXACT_REARM:
                lead = rt;
            default:
            begin
                for (int k = 0; k < 3; k++)
                    axis[k] = int'($urandom_range(0, 65535)) - 32768;
            end
        endcase
        if (shape != SHAPE_NOISE)
        begin
            lane = $urandom_range(0, 2);
            axis[lane] = lead;
            for (int k = 0; k < 3; k++)
                if ($urandom_range(0, 1))
                    axis[k] = -axis[k];
        end
        return sample_at(axis[0], axis[1], axis[2], now, day);
    endfunction

    task automatic queue_sample(input sample_t s);
        sample_queue.push_back(s);
        samples_queued++;
    endtask

    // wait until every request is taken and every result is back
    task automatic wait_idle();
        while (samples_taken != samples_queued || step_results_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        case (idx)
            CFG_STEP_THRESHOLD:  step_thr   = THR_W'(value);
            CFG_REARM_THRESHOLD: rearm_thr  = THR_W'(value);
            CFG_MIN_GAP_MS:      gap_ms     = GAP_W'(value);
            CFG_STEP_GOAL:       goal_steps = COUNT_W'(value);
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // all four registers, upper data bits filled with junk where the register is narrower
    task automatic apply_settings(input int unsigned st, input int unsigned rt,
                                  input int unsigned gap, input int unsigned goal);
        write_reg(CFG_STEP_THRESHOLD, st | ($urandom_range(0, 511) << THR_W));
        write_reg(CFG_REARM_THRESHOLD, rt | ($urandom_range(0, 511) << THR_W));
        write_reg(CFG_MIN_GAP_MS, gap | ($urandom_range(0, 255) << GAP_W));
        write_reg(CFG_STEP_GOAL, goal);
        settings_used++;
    endtask

    // walking pattern: mostly alternating peaks and troughs, with noise and other shapes
    task automatic queue_walk(input int unsigned count);
        int unsigned roll;
        shape_t      shape;
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 12)
                shape = SHAPE_NOISE;
            else if (roll < 16)
                shape = SHAPE_EXACT_STEP;
            else if (roll < 20)
                shape = SHAPE_EXACT_REARM;
            else if (roll < 28)
                shape = SHAPE_BETWEEN;
            else
            begin
                shape = walk_high ? SHAPE_PEAK : SHAPE_TROUGH;
                if ($urandom_range(0, 9) < 6)
                    walk_high = !walk_high;
            end
            roll = $urandom_range(0, 99);
            if (roll < 4)
                walk_ms = $urandom();
            else if (roll >= 9)
                walk_ms = walk_ms + $urandom_range(5, 60);
            roll = $urandom_range(0, 199);
            if (roll < 2)
                walk_day = DAY_W'($urandom_range(1, 99991231));
            if (roll >= 2 && roll < 8)
                queue_sample(make_sample(shape, walk_ms, '0));
            else
                queue_sample(make_sample(shape, walk_ms, walk_day));
        end
    endtask

    // sample request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid   <= 1'b0;
            sample_ch.accel_x <= '0;
            sample_ch.accel_y <= '0;
            sample_ch.accel_z <= '0;
            sample_ch.now_ms  <= '0;
            sample_ch.day_key <= '0;
            send_hold = 0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                step_results_due.push_back(count_step(in_flight));
                samples_taken++;
            end
            if (!(sample_ch.valid && !sample_ch.ready))
            begin
                if (send_hold > 0)
                begin
                    send_hold--;
                    sample_ch.valid <= 1'b0;
                end
                else if (sample_queue.size() > 0)
                begin
                    in_flight = sample_queue.pop_front();
                    sample_ch.valid   <= 1'b1;
                    sample_ch.accel_x <= in_flight.accel_x;
                    sample_ch.accel_y <= in_flight.accel_y;
                    sample_ch.accel_z <= in_flight.accel_z;
                    sample_ch.now_ms  <= in_flight.now_ms;
                    sample_ch.day_key <= in_flight.day_key;
                    send_hold = pick_gap(send_calm);
                end
                else
                begin
                    sample_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // result monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        step_result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            take_hold = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (step_results_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result with none expected, expected nothing, got steps %0d",
                             $time, result_ch.steps_today);
                end
                else
                begin
                    want = step_results_due.pop_front();
                    compare_field("step_counted", want.step_counted, result_ch.step_counted);
                    compare_field("goal_reached", want.goal_reached, result_ch.goal_reached);
                    compare_field("steps_today", want.steps_today, result_ch.steps_today);
                    compare_field("current_day", want.current_day, result_ch.current_day);
                    steps_seen += want.step_counted;
                    goals_seen += want.goal_reached;
                end
                take_hold = pick_gap(take_calm);
            end
            if (take_hold > 0)
            begin
                take_hold--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus
    initial
    begin
        int unsigned st;
        int unsigned rt;
        int unsigned gap;
        int unsigned goal;
        int unsigned roll;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_STEP_THRESHOLD;
        cfg_data          = '0;
        sample_ch.valid   = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        sample_ch.now_ms  = '0;
        sample_ch.day_key = '0;
        result_ch.ready   = 1'b0;
        step_thr          = THR_W'(4833);
        rearm_thr         = THR_W'(4301);
        gap_ms            = MIN_GAP_RST;
        goal_steps        = STEP_GOAL_RST;
        day_steps         = '0;
        held_day          = '0;
        armed             = 1'b1;
        goal_hit          = 1'b0;
        last_step_ms      = '0;
        samples_queued    = 0;
        samples_taken     = 0;
        results_seen      = 0;
        steps_seen        = 0;
        goals_seen        = 0;
        settings_used     = 1;
        errors            = 0;
        send_calm         = 0;
        take_calm         = 0;
        walk_high         = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: unknown day, gap rules, time zero and time wrap
        queue_sample(sample_at(4833, 0, 0, 100, 0));
        queue_sample(sample_at(-32768, 32767, -32768, 200, 0));
        queue_sample(sample_at(0, 0, 0, 300, 0));
        queue_sample(sample_at(0, -4833, 0, 0, 20240101));
        queue_sample(sample_at(0, 0, 4300, 10, 20240101));
        queue_sample(sample_at(0, 0, -4833, 20, 20240101));
        queue_sample(sample_at(4301, 0, 0, 30, 20240101));
        queue_sample(sample_at(100, 0, 0, 40, 20240101));
        queue_sample(sample_at(32767, 0, 0, 100, 20240101));
        queue_sample(sample_at(0, 32767, 0, 300, 20240101));
        queue_sample(sample_at(4500, 0, 0, 400, 20240101));
        queue_sample(sample_at(5000, 0, 0, 800, 20240101));
        queue_sample(sample_at(0, 0, 0, 900, 20240101));
        queue_sample(sample_at(4500, 0, 0, 1000, 20240101));
        queue_sample(sample_at(6000, 0, 0, 32'hFFFF_FF00, 20240101));
        queue_sample(sample_at(0, 0, 0, 32'hFFFF_FFF0, 20240101));
        queue_sample(sample_at(6000, 0, 0, 32'h0000_0100, 20240101));
        queue_sample(sample_at(0, 0, 0, 32'h0000_0110, 0));
        queue_sample(sample_at(6000, 0, 0, 32'h0000_0120, 0));
        queue_sample(sample_at(-32768, -32768, -32768, 32'hFFFF_FFFF, 99991231));
        queue_sample(sample_at(0, 0, 0, 5, 99991231));
        wait_idle();

        // goal crossed once, then lowered below the count, then zero
        write_reg(CFG_STEP_GOAL, 2);
        write_reg(CFG_MIN_GAP_MS, 0);
        settings_used++;
        queue_sample(sample_at(5000, 0, 0, 6, 99991231));
        queue_sample(sample_at(0, 0, 0, 7, 99991231));
        queue_sample(sample_at(0, 5000, 0, 8, 99991231));
        wait_idle();
        write_reg(CFG_STEP_GOAL, 1);
        settings_used++;
        queue_sample(sample_at(0, 0, 0, 9, 99991231));
        queue_sample(sample_at(0, 0, 5000, 10, 99991231));
        wait_idle();
        write_reg(CFG_STEP_GOAL, 0);
        settings_used++;
        queue_sample(sample_at(5000, 0, 0, 11, 20250615));
        wait_idle();

        // extreme settings
        walk_ms  = $urandom();
        walk_day = DAY_W'(20250616);
        apply_settings(32767, 32767, 65535, COUNT_MAX);
        queue_walk(40);
        wait_idle();
        apply_settings(0, 0, 0, 5);
        queue_walk(40);
        wait_idle();

        // random settings, walking patterns
        for (int phase = 0; phase < 8; phase++)
        begin
            roll = $urandom_range(0, 99);
            st = (roll < 12) ? 0 : (roll < 22) ? 32767 : $urandom_range(1500, 9000);
            roll = $urandom_range(0, 99);
            if (roll < 12)
                rt = 0;
            else if (roll < 20)
                rt = 32767;
            else if (roll < 30)
                rt = st;
            else
                rt = (st > 0) ? $urandom_range(0, st - 1) : 0;
            roll = $urandom_range(0, 99);
            gap = (roll < 12) ? 0 : (roll < 20) ? 65535 : $urandom_range(0, 400);
            roll = $urandom_range(0, 99);
            goal = (roll < 10) ? 0 : (roll < 18) ? COUNT_MAX : $urandom_range(1, 40);
            apply_settings(st, rt, gap, goal);
            if ($urandom_range(0, 1))
                walk_day = DAY_W'($urandom_range(1, 99991231));
            queue_walk(90);
            wait_idle();
        end

        $display("checked %0d results: %0d counted steps, %0d goal pulses",
                 results_seen, steps_seen, goals_seen);
        $display("over %0d register settings, including threshold and gap extremes",
                 settings_used);
        if (errors == 0 && step_results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
